/* rtl/spu_pkg.sv */
// Shared types, register indices and a saturation helper of the synapse
// plasticity update block. No dependencies.
package spu_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int SIG_W = 24;
	localparam int STR_W = 16;
	localparam int DEN_W = SIG_W + 1;
	// Widest dividend: a 16-bit gain times a 25-bit difference magnitude.
	localparam int PROD_W = STR_W + DEN_W;
	localparam int N_REGS = 8;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_EARLY = 3'd0,
		REG_FIX = 3'd1,
		REG_ISTR = 3'd2,
		REG_IWEAK = 3'd3,
		REG_CHG = 3'd4,
		REG_MAXS = 3'd5,
		REG_MAXW = 3'd6,
		REG_DISC = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_KEEP,
		MODE_EARLY,
		MODE_FIRED,
		MODE_SILENT
	} mode_t;

	typedef struct packed {
		logic has_recipient;
		logic stage_in;
		logic fired;
		logic signed [STR_W-1:0] strength_in;
		logic [SIG_W-1:0] current_signal;
		logic [SIG_W-1:0] best_signal;
	} in_t;

	typedef struct packed {
		logic signed [STR_W-1:0] strength_out;
		logic stage_out;
		logic detach_request;
		logic connect_request;
	} out_t;

	typedef struct packed {
		logic [15:0] early_window;
		logic [15:0] fixation_level;
		logic signed [15:0] initial_strengthen;
		logic signed [15:0] initial_weaken;
		logic [15:0] change_size;
		logic signed [15:0] max_strengthen;
		logic signed [15:0] max_weaken;
		logic signed [15:0] disconnect_level;
	} cfg_t;

	// Per-synapse data that rides alongside the divider.
	typedef struct packed {
		mode_t mode;
		logic stage;
		logic connect;
		logic neg;
		logic zero_best;
		logic signed [STR_W-1:0] strength;
		logic signed [STR_W-1:0] early_strength;
		logic early_detach;
	} ctx_t;

	function automatic logic signed [STR_W-1:0] sat17(input logic signed [STR_W:0] v);
		logic signed [STR_W-1:0] r;
		if (v[STR_W] != v[STR_W-1]) begin
			r = v[STR_W] ? {1'b1, {(STR_W-1){1'b0}}} : {1'b0, {(STR_W-1){1'b1}}};
		end else begin
			r = v[STR_W-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/spu_div_cell.sv */
// One restoring-division cell: produces one quotient bit per cycle while enabled and passes
// the partial remainder and the synapse context on. Depends on spu_pkg.
module spu_div_cell import spu_pkg::*; #(
	parameter int DW = DEN_W,
	parameter int NW = PROD_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_i,
	input  ctx_t          ctx_i,
	input  logic [DW-1:0] den_i,
	input  logic [DW-1:0] rem_i,
	input  logic [NW-1:0] nq_i,
	output logic          valid_q,
	output ctx_t          ctx_q,
	output logic [DW-1:0] den_q,
	output logic [DW-1:0] rem_q,
	output logic [NW-1:0] nq_q
);

	logic [DW:0] trial;
	logic        ge;
	logic [DW:0] diff;

	assign trial = {rem_i, nq_i[NW-1]};
	assign ge = trial >= {1'b0, den_i};
	assign diff = trial - {1'b0, den_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q <= ctx_i;
			den_q <= den_i;
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			nq_q <= {nq_i[NW-2:0], ge};
		end
	end

endmodule

/* rtl/spu_front.sv */
// Front stages: case decode and early step (stage 1), dividend and divisor
// selection with the gain multiply (stage 2). Depends on spu_pkg.
module spu_front import spu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int NW = PROD_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  in_t              in_data,
	input  cfg_t             cfg,
	output logic             valid_s2,
	output ctx_t             ctx_s2,
	output logic [NW-1:0]    num_s2,
	output logic [DEN_W-1:0] den_s2
);

	localparam int CW = (SIG_W > 16 + FRAC_BITS) ? SIG_W : 16 + FRAC_BITS;

	logic [CW-1:0]          best_c;
	logic [CW-1:0]          fix_c;
	logic [CW-1:0]          early_c;
	logic                   stage_c;
	logic                   early_hit;
	logic signed [STR_W:0]  early_sum;
	logic signed [STR_W-1:0] early_sat;
	logic signed [SIG_W+1:0] diff;
	ctx_t                   ctx_c;

	logic                   valid_s1;
	ctx_t                   ctx_s1;
	logic [DEN_W-1:0]       absdiff_s1;
	logic [SIG_W-1:0]       cur_s1;
	logic [SIG_W-1:0]       best_s1;

	logic [PROD_W-1:0]      prod;

	always_comb begin
		best_c = CW'(in_data.best_signal);
		fix_c = CW'(cfg.fixation_level) << FRAC_BITS;
		early_c = CW'(cfg.early_window) << FRAC_BITS;
		stage_c = in_data.stage_in | (best_c > fix_c);
		early_hit = best_c < early_c;
		early_sum = {in_data.strength_in[STR_W-1], in_data.strength_in}
			+ (in_data.fired ? {cfg.initial_strengthen[15], cfg.initial_strengthen}
				: {cfg.initial_weaken[15], cfg.initial_weaken});
		early_sat = sat17(early_sum);
		diff = $signed({1'b0, in_data.current_signal, 1'b0})
			- $signed({2'b00, in_data.best_signal});

		ctx_c.stage = stage_c;
		ctx_c.connect = !in_data.has_recipient;
		ctx_c.strength = in_data.strength_in;
		ctx_c.early_strength = early_sat;
		ctx_c.early_detach = !in_data.fired && (early_sat < cfg.disconnect_level);
		ctx_c.zero_best = in_data.best_signal == '0;
		if (!in_data.has_recipient || stage_c) begin
			ctx_c.mode = MODE_KEEP;
		end else if (early_hit) begin
			ctx_c.mode = MODE_EARLY;
		end else if (in_data.fired) begin
			ctx_c.mode = MODE_FIRED;
		end else begin
			ctx_c.mode = MODE_SILENT;
		end
		// The silent rule always takes the quotient as a non-positive amount.
		ctx_c.neg = in_data.fired ? diff[SIG_W+1] : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign prod = PROD_W'(cfg.change_size) * PROD_W'(absdiff_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_c;
			absdiff_s1 <= diff[SIG_W+1] ? DEN_W'(-diff) : DEN_W'(diff);
			cur_s1 <= in_data.current_signal;
			best_s1 <= in_data.best_signal;

			ctx_s2 <= ctx_s1;
			if (ctx_s1.mode == MODE_FIRED) begin
				num_s2 <= NW'(prod);
				den_s2 <= DEN_W'(cur_s1) + DEN_W'(1);
			end else begin
				num_s2 <= NW'(cur_s1) << FRAC_BITS;
				den_s2 <= DEN_W'(best_s1);
			end
		end
	end

endmodule

/* rtl/synapse_plasticity_update_top.sv */
// Top level of the synapse plasticity update: register file, front stages,
// a chain of divider cells and the clamp and saturate stage. Depends on
// spu_pkg, spu_front and spu_div_cell.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    in_data (in_t)
//  out       output     out_valid / out_stall  out_data (out_t)
//  cfg       input      cfg_we                 cfg_idx, cfg_wdata
//
// One transaction is accepted per cycle while the output is not stalled. NW
// (41 at the default width) is the number of divider cells, one quotient bit
// each. Reset loads the register defaults and empties the pipeline. A stalled
// output holds the whole pipeline, and in_stall follows out_stall then.
module synapse_plasticity_update_top import spu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [IDX_W-1:0]     cfg_idx,
	input  logic [15:0]          cfg_wdata
);

	localparam int NW = (PROD_W > SIG_W + FRAC_BITS) ? PROD_W : SIG_W + FRAC_BITS;

	cfg_t cfg_q;
	logic en;

	logic             valid_c [NW+1];
	ctx_t             ctx_c   [NW+1];
	logic [DEN_W-1:0] den_c   [NW+1];
	logic [DEN_W-1:0] rem_c   [NW+1];
	logic [NW-1:0]    nq_c    [NW+1];

	logic signed [NW:0]     amt;
	logic signed [NW:0]     maxs_w;
	logic signed [NW:0]     maxw_w;
	logic signed [NW:0]     clamp_hi;
	logic signed [NW:0]     late_amt;
	logic signed [STR_W:0]  late_sum;
	logic signed [STR_W-1:0] late_sat;
	out_t                   res;
	ctx_t                   ctx_f;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.early_window <= 16'd30;
			cfg_q.fixation_level <= 16'd270;
			cfg_q.initial_strengthen <= 16'sd10;
			cfg_q.initial_weaken <= -16'sd51;
			cfg_q.change_size <= 16'd26;
			cfg_q.max_strengthen <= 16'sd26;
			cfg_q.max_weaken <= -16'sd77;
			cfg_q.disconnect_level <= 16'sd77;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_EARLY: cfg_q.early_window <= cfg_wdata;
				REG_FIX:   cfg_q.fixation_level <= cfg_wdata;
				REG_ISTR:  cfg_q.initial_strengthen <= cfg_wdata;
				REG_IWEAK: cfg_q.initial_weaken <= cfg_wdata;
				REG_CHG:   cfg_q.change_size <= cfg_wdata;
				REG_MAXS:  cfg_q.max_strengthen <= cfg_wdata;
				REG_MAXW:  cfg_q.max_weaken <= cfg_wdata;
				REG_DISC:  cfg_q.disconnect_level <= cfg_wdata;
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	spu_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.in_data(in_data),
		.cfg(cfg_q),
		.valid_s2(valid_c[0]),
		.ctx_s2(ctx_c[0]),
		.num_s2(nq_c[0]),
		.den_s2(den_c[0])
	);

	assign rem_c[0] = '0;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		spu_div_cell #(.DW(DEN_W), .NW(NW)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_i(valid_c[i]),
			.ctx_i(ctx_c[i]),
			.den_i(den_c[i]),
			.rem_i(rem_c[i]),
			.nq_i(nq_c[i]),
			.valid_q(valid_c[i+1]),
			.ctx_q(ctx_c[i+1]),
			.den_q(den_c[i+1]),
			.rem_q(rem_c[i+1]),
			.nq_q(nq_c[i+1])
		);
	end

	// Signed amount from the quotient magnitude, then the clamps of each rule.
	always_comb begin
		ctx_f = ctx_c[NW];
		amt = ctx_f.neg ? -$signed({1'b0, nq_c[NW]}) : $signed({1'b0, nq_c[NW]});
		maxs_w = (NW+1)'(cfg_q.max_strengthen);
		maxw_w = (NW+1)'(cfg_q.max_weaken);
		clamp_hi = (amt > maxs_w) ? maxs_w : amt;
		if (ctx_f.mode == MODE_FIRED) begin
			late_amt = (clamp_hi < maxw_w) ? maxw_w : clamp_hi;
		end else if (ctx_f.zero_best) begin
			late_amt = maxw_w;
		end else begin
			late_amt = (amt < maxw_w) ? maxw_w : amt;
		end
		late_sum = {ctx_f.strength[STR_W-1], ctx_f.strength}
			+ {late_amt[STR_W-1], late_amt[STR_W-1:0]};
		late_sat = sat17(late_sum);

		res.stage_out = ctx_f.stage;
		res.connect_request = ctx_f.connect;
		case (ctx_f.mode)
			MODE_EARLY: begin
				res.strength_out = ctx_f.early_strength;
				res.detach_request = ctx_f.early_detach;
			end
			MODE_FIRED: begin
				res.strength_out = late_sat;
				res.detach_request = 1'b0;
			end
			MODE_SILENT: begin
				res.strength_out = late_sat;
				res.detach_request = late_sat < cfg_q.disconnect_level;
			end
			default: begin
				res.strength_out = ctx_f.strength;
				res.detach_request = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_c[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= res;
		end
	end

endmodule

/* test/tb_synapse_plasticity_update_top.sv */
`timescale 1ns / 1ps
// Testbench of the synapse plasticity update block: directed table plus random
// transactions, checked against a behavioral predictor. Depends on spu_pkg and the top.
module tb_synapse_plasticity_update_top;
	import spu_pkg::*;

	localparam int F = FRAC_BITS_DEF;
	localparam int LATENCY = 48;
	localparam int WATCHDOG = 20000;

	typedef struct {
		in_t item;
		bit has_exp;
		out_t exp_res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_idx = '0;
	logic [15:0] cfg_wdata = '0;

	logic [15:0] regs [N_REGS];
	out_t update_q [$];
	int errors = 0;
	int idle_cycles = 0;
	bit stall_random = 1'b1;

	synapse_plasticity_update_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint sx(logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic out_t predict_update(in_t s);
		out_t r;
		longint str, cur, best, amt;
		bit stage, det;
		str = longint'(s.strength_in);
		cur = longint'(s.current_signal);
		best = longint'(s.best_signal);
		stage = s.stage_in;
		det = 1'b0;
		if (best > (longint'(regs[REG_FIX]) << F)) stage = 1'b1;
		if (s.has_recipient && !stage) begin
			if (best < (longint'(regs[REG_EARLY]) << F)) begin
				if (s.fired) begin
					str = clip16(str + sx(regs[REG_ISTR]));
				end else begin
					str = clip16(str + sx(regs[REG_IWEAK]));
					det = str < sx(regs[REG_DISC]);
				end
			end else if (s.fired) begin
				amt = (longint'(regs[REG_CHG]) * (2 * cur - best)) / (cur + 1);
				if (amt > sx(regs[REG_MAXS])) amt = sx(regs[REG_MAXS]);
				if (amt < sx(regs[REG_MAXW])) amt = sx(regs[REG_MAXW]);
				str = clip16(str + amt);
			end else begin
				if (best == 0) amt = sx(regs[REG_MAXW]);
				else amt = -((cur << F) / best);
				if (amt < sx(regs[REG_MAXW])) amt = sx(regs[REG_MAXW]);
				str = clip16(str + amt);
				det = str < sx(regs[REG_DISC]);
			end
		end
		r.strength_out = str[15:0];
		r.stage_out = stage;
		r.detach_request = det;
		r.connect_request = !s.has_recipient;
		return r;
	endfunction

	// Receiver: stall pattern of its own, checked at each accepted transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (update_q.size() == 0) begin
					$error("unexpected result %h", out_data);
					errors++;
				end else begin
					out_t e;
					e = update_q.pop_front();
					if (out_data.strength_out !== e.strength_out) begin
						$error("strength_out expected %0d actual %0d", e.strength_out,
							out_data.strength_out);
						errors++;
					end
					if (out_data.stage_out !== e.stage_out) begin
						$error("stage_out expected %0d actual %0d", e.stage_out,
							out_data.stage_out);
						errors++;
					end
					if (out_data.detach_request !== e.detach_request) begin
						$error("detach_request expected %0d actual %0d",
							e.detach_request, out_data.detach_request);
						errors++;
					end
					if (out_data.connect_request !== e.connect_request) begin
						$error("connect_request expected %0d actual %0d",
							e.connect_request, out_data.connect_request);
						errors++;
					end
				end
			end
			if (!stall_random) out_stall <= 1'b0;
			else if ($urandom_range(0, 63) < 8) out_stall <= ~out_stall;
			else if (out_stall && $urandom_range(0, 3) == 0) out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The write enable drops for one cycle between writes.
	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		regs[idx] = val;
		@(posedge clk);
	endtask

	task automatic drain();
		while (update_q.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// Holds valid until the transaction is taken; the caller drops it later.
	task automatic send(in_t s, bit use_exp, out_t e);
		in_valid <= 1'b1;
		in_data <= s;
		update_q.push_back(use_exp ? e : predict_update(s));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic idle_gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	function automatic in_t rand_item(int mode);
		in_t s;
		s.has_recipient = ($urandom_range(0, 7) != 0);
		s.stage_in = ($urandom_range(0, 5) == 0);
		s.fired = 1'($urandom_range(0, 1));
		s.strength_in = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 600) - 100);
		case ($urandom_range(0, 5))
			0: s.best_signal = 24'($urandom);
			1: s.best_signal = 24'($urandom_range(0, 3));
			default: s.best_signal = 24'($urandom_range(0, 400 << F));
		endcase
		case ($urandom_range(0, 4))
			0: s.current_signal = 24'($urandom);
			1: s.current_signal = 24'($urandom_range(0, 3));
			default: s.current_signal = 24'($urandom_range(0, s.best_signal + 512));
		endcase
		return s;
	endfunction

	function automatic in_t mk(bit h, bit st, bit f, logic [15:0] str, int cur, int best);
		in_t s;
		s.has_recipient = h;
		s.stage_in = st;
		s.fired = f;
		s.strength_in = str;
		s.current_signal = 24'(cur);
		s.best_signal = 24'(best);
		return s;
	endfunction

	function automatic out_t mo(logic [15:0] str, bit st, bit d, bit c);
		out_t r;
		r.strength_out = str;
		r.stage_out = st;
		r.detach_request = d;
		r.connect_request = c;
		return r;
	endfunction

	initial begin
		row_t table_rows [$];
		in_t s;
		int burst;
		regs[REG_EARLY] = 16'd30;
		regs[REG_FIX] = 16'd270;
		regs[REG_ISTR] = 16'd10;
		regs[REG_IWEAK] = 16'hFFCD;
		regs[REG_CHG] = 16'd26;
		regs[REG_MAXS] = 16'd26;
		regs[REG_MAXW] = 16'hFFB3;
		regs[REG_DISC] = 16'd77;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at reset settings.
		table_rows.push_back('{mk(0, 0, 1, 16'h1234, 5, 5), 1, mo(16'h1234, 0, 0, 1)});
		table_rows.push_back('{mk(1, 1, 0, 16'h8000, 0, 0), 1, mo(16'h8000, 1, 0, 0)});
		table_rows.push_back('{mk(1, 0, 1, 16'd100, 0, 0), 1, mo(16'd110, 0, 0, 0)});
		table_rows.push_back('{mk(1, 0, 0, 16'd200, 0, 0), 1, mo(16'd149, 0, 0, 0)});
		table_rows.push_back('{mk(1, 0, 0, 16'd100, 0, 0), 1, mo(16'd49, 0, 1, 0)});
		table_rows.push_back('{mk(1, 0, 1, 16'h7FFF, 0, 0), 1, mo(16'h7FFF, 0, 0, 0)});
		table_rows.push_back('{mk(1, 0, 0, 16'h8000, 0, 0), 1, mo(16'h8000, 0, 1, 0)});
		table_rows.push_back('{mk(1, 0, 0, 16'd0, 24'hFFFFFF, 24'hFFFFFF), 1,
			mo(16'd0, 1, 0, 0)});
		table_rows.push_back('{mk(1, 0, 1, 16'd500, 100 << F, 100 << F), 0, '0});
		table_rows.push_back('{mk(1, 0, 1, 16'd500, 0, 200 << F), 0, '0});
		table_rows.push_back('{mk(1, 0, 0, 16'd500, 100 << F, 100 << F), 0, '0});
		table_rows.push_back('{mk(1, 0, 0, 16'd100, 1, 30 << F), 0, '0});
		table_rows.push_back('{mk(1, 0, 0, 16'd0, 24'hFFFFFF, 270 << F), 0, '0});
		table_rows.push_back('{mk(1, 0, 1, 16'h7FFF, 24'hFFFFFF, 270 << F), 0, '0});
		table_rows.push_back('{mk(1, 0, 1, 16'd300, 50 << F, (30 << F) - 1), 0, '0});
		foreach (table_rows[i]) begin
			send(table_rows[i].item, table_rows[i].has_exp, table_rows[i].exp_res);
			if ($urandom_range(0, 2) == 0) idle_gap();
		end
		in_valid <= 1'b0;
		drain();

		// Zero best in the late silent rule needs an early window of zero.
		write_reg(REG_EARLY, 16'd0);
		send(mk(1, 0, 0, 16'd300, 5, 0), 1, mo(16'd223, 0, 0, 0));
		send(mk(1, 0, 0, 16'd100, 5, 0), 1, mo(16'd23, 0, 1, 0));
		in_valid <= 1'b0;
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: begin
					write_reg(REG_EARLY, 16'hFFFF);
					write_reg(REG_FIX, 16'hFFFF);
					write_reg(REG_ISTR, 16'h7FFF);
					write_reg(REG_IWEAK, 16'h8000);
					write_reg(REG_CHG, 16'hFFFF);
					write_reg(REG_MAXS, 16'h7FFF);
					write_reg(REG_MAXW, 16'h8000);
					write_reg(REG_DISC, 16'h7FFF);
				end
				2: begin
					write_reg(REG_EARLY, 16'd0);
					write_reg(REG_FIX, 16'd0);
					write_reg(REG_ISTR, 16'h8000);
					write_reg(REG_IWEAK, 16'h7FFF);
					write_reg(REG_CHG, 16'd0);
					write_reg(REG_MAXS, 16'h8000);
					write_reg(REG_MAXW, 16'h7FFF);
					write_reg(REG_DISC, 16'h8000);
				end
				default: if (phase > 0) begin
					write_reg(REG_EARLY, 16'($urandom_range(0, 60)));
					write_reg(REG_FIX, 16'($urandom_range(100, 500)));
					write_reg(REG_ISTR, 16'($urandom));
					write_reg(REG_IWEAK, 16'($urandom));
					write_reg(REG_CHG, 16'($urandom));
					write_reg(REG_MAXS, 16'($urandom_range(0, 300)));
					write_reg(REG_MAXW, 16'(-$urandom_range(0, 300)));
					write_reg(REG_DISC, 16'($urandom));
				end
			endcase
			stall_random = (phase != 4);
			for (int n = 0; n < 300; ) begin
				burst = $urandom_range(1, 40);
				for (int b = 0; b < burst && n < 300; b++, n++) begin
					s = rand_item(phase % 2);
					send(s, 0, '0);
				end
				if (phase != 4) idle_gap();
			end
			in_valid <= 1'b0;
			drain();
		end

		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
rtl/spu_pkg.sv
rtl/spu_div_cell.sv
rtl/spu_front.sv
rtl/synapse_plasticity_update_top.sv
test/tb_synapse_plasticity_update_top.sv
